### rtl/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the dataset summary statistics block.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int ValueW = 24;
  localparam int CountW = 11;
  // Q12.12 samples; roots of Q24.24 mean squares land back in Q12.12.
  localparam int FractionBits = 12;

  // One beat handed from the loader to the statistics engine.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              has_value;
    logic              last;
  } dss_beat_t;

endpackage

### rtl/dss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_queue
// Small FIFO between the input front end and the statistics engine.
// ----------------------------------------------------------------------------
module dss_queue import dss_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  dss_beat_t push_beat,
  output logic      full,
  input  logic      pop,
  output dss_beat_t pop_beat,
  output logic      not_empty
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  dss_beat_t     slots [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;

  assign full      = (fill == (AW+1)'(Depth));
  assign not_empty = (fill != '0);
  assign pop_beat  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) !not_empty |-> !pop)
    else $error("queue underrun");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 1'b1))
    else $error("fill count slip");
endmodule

### rtl/dss_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_engine
// Stores samples, and on a closing beat ranks them by counting passes over
// the memory, divides and takes square roots serially.
// ----------------------------------------------------------------------------
module dss_engine import dss_pkg::*; #(
  parameter int MaxSamples   = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat_valid,
  input  dss_beat_t         beat,
  output logic              beat_pop,
  output logic              idle,
  output logic              res_valid,
  output logic [CountW-1:0] res_count,
  output logic [ValueW-1:0] res_max,
  output logic [ValueW-1:0] res_mean,
  output logic [ValueW-1:0] res_median,
  output logic [ValueW-1:0] res_rms,
  output logic [ValueW-1:0] res_stddev,
  output logic              res_overflowed
);
  localparam int AW  = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int NW  = $clog2(MaxSamples + 1);
  localparam int SW  = ValueW + NW;       // sum width
  localparam int QW  = 2 * ValueW + NW;   // square-sum width
  localparam int DW  = QW;                // dividend width
  localparam int RW  = 2 * ValueW;        // root radicand width

  // Sort: repeated odd-even transposition over the memory is too slow to
  // reason about; use a selection of order statistics instead: the engine
  // only needs max and the two middle ranks. Each rank query counts, for a
  // candidate, how many samples are smaller/equal in one pass; each of the
  // n stored samples is taken in turn as a candidate.
  typedef enum logic [10:0] {
    S_LOAD  = 11'b00000000001,
    S_CAND  = 11'b00000000010,
    S_SCAN  = 11'b00000000100,
    S_DIVM  = 11'b00000001000,
    S_DIVQ  = 11'b00000010000,
    S_VAR   = 11'b00000100000,
    S_DIVV  = 11'b00001000000,
    S_ROOTQ = 11'b00010000000,
    S_ROOTV = 11'b00100000000,
    S_EMIT  = 11'b01000000000,
    S_WAIT  = 11'b10000000000
  } state_t;

  state_t state;

  logic [ValueW-1:0] mem [MaxSamples];
  logic [ValueW-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;

  logic [NW-1:0] n;
  logic [SW-1:0] sum;
  logic [QW-1:0] sqsum;
  logic          dropped;
  logic [ValueW-1:0] maxv;

  // candidate scan
  logic [NW-1:0]     ci;     // candidate index
  logic [NW-1:0]     si;     // scan index (issued address)
  logic              sv;     // read data valid next cycle
  logic [ValueW-1:0] cand;
  logic [NW-1:0]     n_less;
  logic [NW-1:0]     n_leq;
  logic              got_lo, got_hi;
  logic [ValueW-1:0] med_lo, med_hi;
  logic [NW-1:0]     rank_lo, rank_hi;

  // shared divider
  logic [DW-1:0] dv_rem;
  logic [DW-1:0] dv_quo;
  logic [$clog2(DW+1)-1:0] dv_cnt;
  logic [DW:0]   dv_trial;

  logic [ValueW-1:0] mean;
  logic [QW-1:0]     msq;
  logic [QW-1:0]     varsum;
  logic [QW-1:0]     mvar;

  // shared square root, two bits per cycle
  logic [RW-1:0]          rt_x;
  logic [RW-1:0]          rt_res;
  logic [RW-1:0]          rt_bit;
  logic [RW:0]            rt_try;
  logic [ValueW-1:0]      rms;

  logic [ValueW-1:0] diff;
  logic [2*ValueW-1:0] sq;
  logic              sqv;
  logic              accv;   // sq holds a term to accumulate

  assign idle     = (state == S_LOAD);
  assign beat_pop = beat_valid && (state == S_LOAD);
  assign wr_en    = beat_pop && beat.has_value && (n < NW'(MaxSamples));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[n[AW-1:0]] <= beat.value;
    end
    rd_data <= mem[rd_addr];
  end

  assign rd_addr  = (state == S_CAND) ? ci[AW-1:0] : si[AW-1:0];
  assign dv_trial = {dv_rem[DW-1:0], dv_quo[DW-1]} - {{(DW+1-NW){1'b0}}, n};
  assign rt_try   = {1'b0, rt_x} - ({1'b0, rt_res} + {1'b0, rt_bit});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      n         <= '0;
      sum       <= '0;
      sqsum     <= '0;
      dropped   <= 1'b0;
      res_valid <= 1'b0;
      sv        <= 1'b0;
      sqv       <= 1'b0;
      accv      <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (beat_pop) begin
            if (beat.has_value) begin
              if (n < NW'(MaxSamples)) begin
                n     <= n + 1'b1;
                sum   <= sum + SW'(beat.value);
                sqsum <= sqsum + QW'(beat.value) * QW'(beat.value);
              end else begin
                dropped <= 1'b1;
              end
            end
            if (beat.last) begin
              ci      <= '0;
              maxv    <= '0;
              got_lo  <= 1'b0;
              got_hi  <= 1'b0;
              med_lo  <= '0;
              med_hi  <= '0;
              state   <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          // ranks for the middle (0-based): lo = (n-1)/2, hi = n/2
          rank_lo <= (n - 1'b1) >> 1;
          rank_hi <= n >> 1;
          if (n == '0) begin
            mean <= '0; rms <= '0; res_stddev <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_CAND;
          end
        end
        S_CAND: begin
          // address ci issued this cycle
          si     <= '0;
          sv     <= 1'b0;
          n_less <= '0;
          n_leq  <= '0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (si == '0 && !sv) begin
            cand <= rd_data;
            if (rd_data > maxv) maxv <= rd_data;
          end
          if (sv) begin
            if (rd_data < cand) n_less <= n_less + 1'b1;
            if (rd_data <= cand) n_leq <= n_leq + 1'b1;
          end
          if (si < n) begin
            si <= si + 1'b1;
            sv <= 1'b1;
          end else if (sv) begin
            sv <= 1'b0;
          end else begin
            // candidate of ranks [n_less, n_leq-1]
            if (n_less <= rank_lo && rank_lo < n_leq) begin
              med_lo <= cand; got_lo <= 1'b1;
            end
            if (n_less <= rank_hi && rank_hi < n_leq) begin
              med_hi <= cand; got_hi <= 1'b1;
            end
            if (ci + 1'b1 == n) begin
              dv_rem <= '0;
              dv_quo <= DW'(sum);
              dv_cnt <= ($clog2(DW+1))'(DW);
              state  <= S_DIVM;
            end else begin
              ci    <= ci + 1'b1;
              state <= S_CAND;
            end
          end
        end
        S_DIVM, S_DIVQ, S_DIVV: begin
          if (dv_cnt != '0) begin
            if (!dv_trial[DW]) begin
              dv_rem <= dv_trial[DW-1:0];
              dv_quo <= {dv_quo[DW-2:0], 1'b1};
            end else begin
              dv_rem <= {dv_rem[DW-2:0], dv_quo[DW-1]};
              dv_quo <= {dv_quo[DW-2:0], 1'b0};
            end
            dv_cnt <= dv_cnt - 1'b1;
          end else begin
            dv_rem <= '0;
            dv_cnt <= ($clog2(DW+1))'(DW);
            if (state == S_DIVM) begin
              mean   <= dv_quo[ValueW-1:0];
              dv_quo <= sqsum;
              state  <= S_DIVQ;
            end else if (state == S_DIVQ) begin
              msq    <= dv_quo;
              si     <= '0;
              sv     <= 1'b0;
              sqv    <= 1'b0;
              accv   <= 1'b0;
              varsum <= '0;
              state  <= S_VAR;
            end else begin
              mvar   <= dv_quo;
              rt_x   <= RW'(msq);
              rt_res <= '0;
              rt_bit <= RW'(1) << (RW - 2);
              state  <= S_ROOTQ;
            end
          end
        end
        S_VAR: begin
          if (sv) begin
            diff <= (rd_data >= mean) ? rd_data - mean : mean - rd_data;
          end
          if (sqv) begin
            sq <= diff * diff;
          end
          if (si < n) begin
            si <= si + 1'b1;
            sv <= 1'b1;
          end else begin
            sv <= 1'b0;
          end
          sqv  <= sv;
          accv <= sqv;
          if (accv) varsum <= varsum + QW'(sq);
          if (!sv && !sqv && !accv && si == n) begin
            dv_quo <= varsum;
            state  <= S_DIVV;
          end
        end
        S_ROOTQ, S_ROOTV: begin
          if (rt_bit != '0) begin
            if (!rt_try[RW]) begin
              rt_x   <= rt_try[RW-1:0];
              rt_res <= (rt_res >> 1) + rt_bit;
            end else begin
              rt_res <= rt_res >> 1;
            end
            rt_bit <= rt_bit >> 2;
          end else if (state == S_ROOTQ) begin
            rms    <= rt_res[ValueW-1:0];
            rt_x   <= RW'(mvar);
            rt_res <= '0;
            rt_bit <= RW'(1) << (RW - 2);
            state  <= S_ROOTV;
          end else begin
            res_stddev <= rt_res[ValueW-1:0];
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          res_valid      <= 1'b1;
          res_count      <= CountW'(n);
          res_max        <= maxv;
          res_mean       <= mean;
          res_median     <= ValueW'(({1'b0, med_lo} + {1'b0, med_hi}) >> 1);
          res_rms        <= rms;
          res_overflowed <= dropped;
          n       <= '0;
          sum     <= '0;
          sqsum   <= '0;
          dropped <= 1'b0;
          state   <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !res_valid) else $error("double result");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !beat_pop) else $error("pop while busy");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    n <= NW'(MaxSamples)) else $error("count beyond capacity");
  a_median_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && n != '0) |-> (got_lo && got_hi))
    else $error("middle rank not found");
endmodule

### rtl/dataset_summary_statistics_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dataset_summary_statistics_top
// Collects Q12.12 samples and reports count, max, mean, median, rms, stddev.
// ----------------------------------------------------------------------------
//  channel | signals                                   | flow
//  input   | start, busy, value, has_value, last       | beat on start && !busy
//  result  | done, count .. overflowed                 | one-cycle strobe on done
//
// Loading: one beat per cycle unless busy, into a 4-entry queue feeding the engine.
// Closing beat: rank scans over the stored samples (one memory read port),
// then three serial divisions, a variance pass and two 24-step roots
// before done. Beats behind a closing beat fill the queue; once it holds
// four, busy stays high until the engine pops again.
// Reset (rst, synchronous) empties the queue and clears the running set.
// The receiver cannot stall: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module dataset_summary_statistics_top import dss_pkg::*; #(
  parameter int MAX_SAMPLES   = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [ValueW-1:0] value,
  input  logic              has_value,
  input  logic              last,
  output logic              done,
  output logic [CountW-1:0] count,
  output logic [ValueW-1:0] max_value,
  output logic [ValueW-1:0] mean,
  output logic [ValueW-1:0] median,
  output logic [ValueW-1:0] rms,
  output logic [ValueW-1:0] stddev,
  output logic              overflowed
);
  dss_beat_t in_beat;
  dss_beat_t q_beat;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  logic      eng_idle;
  logic      accept;

  assign in_beat = '{value: value, has_value: has_value, last: last};
  // Busy while the queue is full; items queue up behind a closing beat.
  assign busy    = q_full;
  assign accept  = start && !busy;

  dss_queue #(.Depth(4)) u_queue (
    .clk(clk), .rst(rst),
    .push(accept), .push_beat(in_beat), .full(q_full),
    .pop(q_pop), .pop_beat(q_beat), .not_empty(q_valid)
  );

  dss_engine #(.MaxSamples(MAX_SAMPLES)) u_engine (
    .clk(clk), .rst(rst),
    .beat_valid(q_valid), .beat(q_beat), .beat_pop(q_pop), .idle(eng_idle),
    .res_valid(done), .res_count(count), .res_max(max_value), .res_mean(mean),
    .res_median(median), .res_rms(rms), .res_stddev(stddev),
    .res_overflowed(overflowed)
  );

  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> !accept) else $error("accept while busy");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> eng_idle) else $error("pop while engine busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> eng_idle) else $error("result outside idle");
endmodule
